[design/tsis_pkg.sv]
`default_nettype none

package tsis_pkg;

  // Word widths fixed by the interface.
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  // Default number of cells and the capacity after reset.
  localparam int DEPTH_DEFAULT = 16;
  localparam int CAP_RESET     = 16;

  // Status code carried with every result word.
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_DATA     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic                    ins;
    logic signed [VAL_W-1:0] x;
  } cell_ctl_t;

endpackage

`default_nettype wire

[design/tsis_cell.sv]
`default_nettype none

module tsis_cell (
  input  logic                             clk,
  input  tsis_pkg::cell_ctl_t              ctl,
  input  logic                             occ,
  input  logic                             below_occ,
  input  logic                             below_gt,
  input  logic signed [tsis_pkg::VAL_W-1:0] below_val,
  output logic signed [tsis_pkg::VAL_W-1:0] val,
  output logic                             gt
);
  import tsis_pkg::*;

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;
  logic                    wr;

  // This cell holds a value strictly larger than the new word.
  assign gt = occ & (ctl.x < val_r);

  // A larger entry moves up, and the first free cell above the stored run takes part too.
  assign wr = ctl.ins & (gt | (~occ & below_occ));

  // The entry below moves up if it is also larger; otherwise the new word lands here.
  always_comb begin
    val_nxt = val_r;
    if (wr) begin
      val_nxt = below_gt ? below_val : ctl.x;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

`default_nettype wire

[design/two_stack_insertion_sorter_core.sv]
`default_nettype none
// Insert: status word in the cycle after acceptance; one insert per cycle while not draining.
// Drain of N stored entries: N data words, one per cycle, passing the state register and then
// the result registers; busy stays high until the chain's single readout port has read them all.
// Drain of an empty store: one status word in the cycle after acceptance, busy stays low.
// Synchronous active-low reset empties the store and sets capacity to 16.
// The receiver cannot stall: every word is on the out_ ports for exactly one cycle.

module two_stack_insertion_sorter_core #(
  parameter int DEPTH = tsis_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_operation,
  input  logic signed [tsis_pkg::VAL_W-1:0] in_value,
  input  logic                              cfg_we,
  input  logic [tsis_pkg::CAP_W-1:0]        cfg_wdata,
  output logic                              out_valid,
  output logic signed [tsis_pkg::VAL_W-1:0] out_result_value,
  output logic [1:0]                        out_status,
  output logic                              out_last
);
  import tsis_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic [CAP_W-1:0]        cap_r;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    accept;
  logic                    full;
  logic [CW-1:0]           fill_m1;
  logic [IW-1:0]           rd_idx;
  cell_ctl_t               ctl;
  logic                    occ      [DEPTH];
  logic                    cell_gt  [DEPTH];
  logic signed [VAL_W-1:0] cell_val [DEPTH];

  assign busy   = (state_r == S_DRAIN);
  assign accept = start & ~busy;

  // Full when the count reaches the capacity or the number of cells.
  assign full = (MW'(fill_r) >= MW'(cap_r)) || (MW'(fill_r) >= MW'(DEPTH));

  assign ctl.ins = accept & ~in_operation & ~full;
  assign ctl.x   = in_value;

  // Chain of cells, bottom cell first.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (CW'(i) < fill_r);
    if (i == 0) begin : g_bot
      tsis_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (occ[i]),
        .below_occ (1'b1),
        .below_gt  (1'b0),
        .below_val ('0),
        .val       (cell_val[i]),
        .gt        (cell_gt[i])
      );
    end else begin : g_mid
      tsis_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (occ[i]),
        .below_occ (occ[i-1]),
        .below_gt  (cell_gt[i-1]),
        .below_val (cell_val[i-1]),
        .val       (cell_val[i]),
        .gt        (cell_gt[i])
      );
    end
  end

  // Readout of the top stored entry.
  assign fill_m1 = fill_r - 1'b1;
  assign rd_idx  = fill_m1[IW-1:0];

  // Control and result word selection.
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = '0;
    out_status_nxt = ST_INSERTED;
    out_last_nxt   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (!in_operation) begin
            if (full) begin
              out_status_nxt = ST_DROPPED;
            end else begin
              out_status_nxt = ST_INSERTED;
              fill_nxt       = fill_r + 1'b1;
            end
          end else if (fill_r == '0) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            out_valid_nxt = 1'b0;
            out_last_nxt  = 1'b0;
            state_nxt     = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = cell_val[rd_idx];
        out_status_nxt = ST_DATA;
        fill_nxt       = fill_m1;
        if (fill_r == CW'(1)) begin
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cap_r       <= CAP_W'(CAP_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Result word registers.
  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

  // The store never holds more entries than it has cells.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    MW'(fill_r) <= MW'(DEPTH))
    else $error("fill count exceeds the number of cells");

  // A drain in progress always has an entry left to read.
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (fill_r != '0))
    else $error("drain running on an empty store");

  // Every drain cycle produces exactly one data word.
  a_drain_word: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && out_status == ST_DATA))
    else $error("drain cycle without a data word");

  // An insert that is taken grows the store by one.
  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> (fill_r == $past(fill_r) + 1'b1))
    else $error("insert did not grow the store");

endmodule

`default_nettype wire

[bench/sorter_bench_pkg.sv]
`timescale 1ns / 1ps

package sorter_bench_pkg;

  // Operation carried by each input word.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DRAIN  = 1'b1
  } sorter_op_t;

endpackage

[bench/sorter_checker.sv]
`timescale 1ns / 1ps

module sorter_checker #(
  parameter int DEPTH = tsis_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic                              in_operation,
  input  logic signed [tsis_pkg::VAL_W-1:0] in_value,
  input  logic                              cfg_we,
  input  logic [tsis_pkg::CAP_W-1:0]        cfg_wdata,
  input  logic                              out_valid,
  input  logic signed [tsis_pkg::VAL_W-1:0] out_result_value,
  input  logic [1:0]                        out_status,
  input  logic                              out_last,
  output int                                fail_count,
  output int                                outstanding
);
  import tsis_pkg::*;
  import sorter_bench_pkg::*;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    status_t                 status;
    logic                    last;
  } result_word_t;

  // Shadow copy of the sorted store and the capacity register.
  logic signed [VAL_W-1:0] shadow_cells [DEPTH];
  int                      shadow_fill;
  logic [CAP_W-1:0]        shadow_capacity;
  result_word_t            expected_words [$];
  int                      errors = 0;

  assign fail_count = errors;

  // Update the shadow store for one accepted word and queue the words it causes.
  task automatic predict_sorted_words(input logic op, input logic signed [VAL_W-1:0] x);
    int limit;
    int pos;
    limit = (shadow_capacity > DEPTH) ? DEPTH : int'(shadow_capacity);
    if (op == OP_INSERT) begin
      if (shadow_fill >= limit || shadow_fill >= DEPTH) begin
        expected_words.push_back('{value: '0, status: ST_DROPPED, last: 1'b1});
      end else begin
        // Lift every strictly larger entry one cell up, stopping at the bottom.
        pos = shadow_fill;
        while (pos > 0 && x < shadow_cells[pos-1]) begin
          shadow_cells[pos] = shadow_cells[pos-1];
          pos--;
        end
        shadow_cells[pos] = x;
        shadow_fill++;
        expected_words.push_back('{value: '0, status: ST_INSERTED, last: 1'b1});
      end
    end else if (shadow_fill == 0) begin
      expected_words.push_back('{value: '0, status: ST_EMPTY, last: 1'b1});
    end else begin
      // Pop from the top, largest first; the bottom entry is marked last.
      while (shadow_fill > 0) begin
        shadow_fill--;
        expected_words.push_back('{value: shadow_cells[shadow_fill], status: ST_DATA,
                                   last: (shadow_fill == 0)});
      end
    end
  endtask

  // Compare result words, follow register writes and predict accepted words.
  always @(posedge clk) begin
    result_word_t want;
    if (!rst_n) begin
      shadow_fill     = 0;
      shadow_capacity = CAP_W'(CAP_RESET);
      expected_words.delete();
    end else begin
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word value=%0d status=%0d last=%0d", $time,
                   out_result_value, out_status, out_last);
        end else begin
          want = expected_words.pop_front();
          if (out_result_value !== want.value || out_status !== want.status ||
              out_last !== want.last) begin
            errors++;
            $display({"%0t: mismatch expected value=%0d status=%0d last=%0d,",
                      " actual value=%0d status=%0d last=%0d"},
                     $time, want.value, want.status, want.last,
                     out_result_value, out_status, out_last);
          end
        end
      end
      if (cfg_we) begin
        shadow_capacity = cfg_wdata;
      end
      if (start && !busy) begin
        predict_sorted_words(in_operation, in_value);
      end
    end
    outstanding <= expected_words.size();
  end

endmodule

[bench/two_stack_insertion_sorter_core_test.sv]
`timescale 1ns / 1ps

module two_stack_insertion_sorter_core_test;
  import tsis_pkg::*;
  import sorter_bench_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic                    in_operation;
  logic signed [VAL_W-1:0] in_value;
  logic                    cfg_we;
  logic [CAP_W-1:0]        cfg_wdata;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_result_value;
  logic [1:0]              out_status;
  logic                    out_last;
  int                      fail_count;
  int                      outstanding;

  // Settings for the random phases.
  int phase_capacity [6] = '{16, 1, 7, 16, 3, 12};
  int phase_idle     [6] = '{0, 81, 0, 26, 81, 26};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  two_stack_insertion_sorter_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  sorter_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  // Present one word and hold it until the block takes it.
  task automatic send_word(input sorter_op_t op, input logic signed [VAL_W-1:0] v);
    start        <= 1'b1;
    in_operation <= op;
    in_value     <= v;
    do @(posedge clk); while (busy);
  endtask

  // Leave the input idle for a random number of cycles.
  task automatic idle_sender(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < pct);
    end
  endtask

  // Stop sending until every expected word has come back.
  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input int c);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= CAP_W'(c);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mix of extremes, a narrow band that forces duplicates, and full-range values.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int narrow;
    narrow = $urandom_range(0, 8);
    case ($urandom_range(0, 7))
      0: return {1'b0, {(VAL_W-1){1'b1}}};
      1: return {1'b1, {(VAL_W-1){1'b0}}};
      2, 3: return narrow - 4;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int sent;
    int burst;
    int cap;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = OP_INSERT;
    in_value     = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Drain of an empty store, then extremes, duplicates and full reordering.
    send_word(OP_DRAIN, 32'sd0);
    send_word(OP_INSERT, {1'b0, {(VAL_W-1){1'b1}}});
    send_word(OP_INSERT, {1'b1, {(VAL_W-1){1'b0}}});
    send_word(OP_INSERT, 32'sd0);
    send_word(OP_INSERT, -32'sd1);
    send_word(OP_INSERT, 32'sd5);
    send_word(OP_INSERT, 32'sd5);
    send_word(OP_INSERT, 32'sd3);
    send_word(OP_DRAIN, -32'sd1);

    // Smallest capacity: the second insert is dropped.
    write_capacity(1);
    send_word(OP_INSERT, 32'sd7);
    send_word(OP_INSERT, 32'sd9);
    send_word(OP_DRAIN, 32'sd0);

    // Descending inserts lift the whole store; a full store drops the next one.
    write_capacity(3);
    send_word(OP_INSERT, 32'sd30);
    send_word(OP_INSERT, 32'sd20);
    send_word(OP_INSERT, 32'sd10);
    send_word(OP_INSERT, 32'sd40);

    // Capacity lowered below the fill level keeps the entries until a drain.
    write_capacity(2);
    send_word(OP_INSERT, 32'sd15);
    send_word(OP_DRAIN, 32'sd0);
    send_word(OP_INSERT, 32'sd1);

    // Random phases: mostly fill-then-drain bursts, some stray words.
    for (int ph = 0; ph < 6; ph++) begin
      cap = phase_capacity[ph];
      write_capacity(cap);
      sent = 0;
      while (sent < 25) begin
        if ($urandom_range(0, 99) < 85) begin
          burst = $urandom_range(0, cap + 2);
          repeat (burst) begin
            idle_sender(phase_idle[ph]);
            send_word(OP_INSERT, pick_value());
          end
          idle_sender(phase_idle[ph]);
          send_word(OP_DRAIN, pick_value());
          sent += burst + 1;
        end else begin
          idle_sender(phase_idle[ph]);
          send_word(sorter_op_t'($urandom_range(0, 1)), pick_value());
          sent++;
        end
        if (ph == 1 && sent >= 12 && sent < 16) begin
          wait_quiet();
        end
      end
    end

    // Let every expected word arrive, then a few more cycles.
    start <= 1'b0;
    for (int n = 0; n < 2000 && outstanding != 0; n++) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[two_stack_insertion_sorter_core.f]
design/tsis_pkg.sv
design/tsis_cell.sv
design/two_stack_insertion_sorter_core.sv
bench/sorter_bench_pkg.sv
bench/sorter_checker.sv
bench/two_stack_insertion_sorter_core_test.sv
